// ===== sv/bnns_pkg.sv =====
// Package for the bitmap nearest-neighbor scaler.
// Holds payload types, register indexes, pipeline stage type and sizing constants.
// No dependencies.
package bnns_pkg;

    localparam int MAX_DIM_DEF   = 128;
    localparam int SRC_BYTES_DEF = 2048;

    localparam int PIX_LANES = 8;
    localparam int ALL_LANES = 9;
    localparam int ROW_LANE  = 8;
    localparam int NUM_W     = 16;
    localparam int QUO_W     = 8;
    localparam int DIV_STEPS = 8;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 4'd3;

    localparam logic [7:0] SIZE_RESET = 8'd64;

    typedef struct packed {
        logic       mode;
        logic [10:0] src_addr;
        logic [7:0]  src_data;
        logic [6:0]  dst_row;
        logic [3:0]  dst_col_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] dst_byte;
        logic       out_of_range;
    } out_item_t;

    typedef struct packed {
        logic                               valid;
        logic                               is_load;
        logic [10:0]                        waddr;
        logic [7:0]                         wdata;
        logic                               oor;
        logic [PIX_LANES-1:0]               mask;
        logic [ALL_LANES-1:0][NUM_W-1:0]    rem;
        logic [ALL_LANES-1:0][QUO_W-1:0]    quo;
    } div_stage_t;

endpackage

// ===== sv/bnns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bnns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bitmap_nearest_neighbor_scaler.sv =====
// Only request items produce a result transfer.
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Cost per item is set by the eight-stage restoring divider and the byte-wide RAM lanes.
// Reset clears all valid bits and sets every size register to 64; source RAM is not cleared.
// Depends on bnns_pkg and bnns_ram.
module bitmap_nearest_neighbor_scaler #(
    parameter int MAX_DIM   = bnns_pkg::MAX_DIM_DEF,
    parameter int SRC_BYTES = bnns_pkg::SRC_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bnns_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bnns_pkg::out_item_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bnns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data
);

    localparam int AW = $clog2(SRC_BYTES);
    localparam int PL = bnns_pkg::PIX_LANES;
    localparam int AL = bnns_pkg::ALL_LANES;
    localparam int NW = bnns_pkg::NUM_W;
    localparam int QW = bnns_pkg::QUO_W;
    localparam int DS = bnns_pkg::DIV_STEPS;

    logic [7:0] src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;

    logic [7:0] sw, sh, tw, th;
    logic [5:0] src_rb, dst_rb;
    logic       en;

    function automatic logic [7:0] clamp_size(input logic [7:0] v, input logic at_least_one);
        logic [7:0] r;
        r = v;
        if (32'(v) > MAX_DIM)
        begin
            r = 8'(MAX_DIM);
        end
        if (at_least_one && (r == 8'd0))
        begin
            r = 8'd1;
        end
        return r;
    endfunction

    assign sw     = clamp_size(src_width_reg, 1'b1);
    assign sh     = clamp_size(src_height_reg, 1'b1);
    assign tw     = clamp_size(dst_width_reg, 1'b0);
    assign th     = clamp_size(dst_height_reg, 1'b0);
    assign src_rb = 6'((9'(sw) + 9'd7) >> 3);
    assign dst_rb = 6'((9'(tw) + 9'd7) >> 3);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bnns_pkg::SIZE_RESET;
            src_height_reg <= bnns_pkg::SIZE_RESET;
            dst_width_reg  <= bnns_pkg::SIZE_RESET;
            dst_height_reg <= bnns_pkg::SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bnns_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                bnns_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data;
                bnns_pkg::REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                bnns_pkg::REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                 out_valid_reg;
    bnns_pkg::out_item_t  out_data_reg;

    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // input stage
    logic               s0_valid_reg;
    bnns_pkg::in_item_t s0_item_reg;

    // divider stages
    bnns_pkg::div_stage_t dv_reg  [0:DS];
    bnns_pkg::div_stage_t dv_next [0:DS];

    always_comb
    begin
        logic [6:0] x;
        dv_next[0]         = '0;
        dv_next[0].valid   = s0_valid_reg;
        dv_next[0].is_load = !s0_item_reg.mode;
        dv_next[0].waddr   = s0_item_reg.src_addr;
        dv_next[0].wdata   = s0_item_reg.src_data;
        dv_next[0].oor     = (tw == 8'd0) || (th == 8'd0)
                           || (8'(s0_item_reg.dst_row) >= th)
                           || (6'(s0_item_reg.dst_col_byte) >= dst_rb);
        for (int b = 0; b < PL; b++)
        begin
            x = {s0_item_reg.dst_col_byte, 3'(b)};
            dv_next[0].mask[b] = (8'(x) < tw);
            dv_next[0].rem[b]  = NW'(NW'(x) * NW'(sw)) + NW'(tw >> 1);
        end
        dv_next[0].rem[bnns_pkg::ROW_LANE] =
            NW'(NW'(s0_item_reg.dst_row) * NW'(sh)) + NW'(th >> 1);
    end

    genvar k;
    generate
        for (k = 1; k <= DS; k++)
        begin : g_div
            always_comb
            begin
                logic [NW-1:0] shifted;
                dv_next[k] = dv_reg[k-1];
                for (int l = 0; l < AL; l++)
                begin
                    shifted = (l == bnns_pkg::ROW_LANE) ? (NW'(th) << (DS - k))
                                                        : (NW'(tw) << (DS - k));
                    if (dv_reg[k-1].rem[l] >= shifted)
                    begin
                        dv_next[k].rem[l]          = dv_reg[k-1].rem[l] - shifted;
                        dv_next[k].quo[l][DS - k]  = 1'b1;
                    end
                end
            end
        end
    endgenerate

    // address stage
    logic             ad_valid_next, ad_load_next, ad_wok_next, ad_oor_next;
    logic [AW-1:0]    ad_waddr_next;
    logic [7:0]       ad_wdata_next;
    logic [PL-1:0]    ad_mask_next, ad_ok_next;
    logic [AW-1:0]    ad_addr_next [0:PL-1];
    logic [2:0]       ad_sel_next  [0:PL-1];

    logic             ad_valid_reg, ad_load_reg, ad_wok_reg, ad_oor_reg;
    logic [AW-1:0]    ad_waddr_reg;
    logic [7:0]       ad_wdata_reg;
    logic [PL-1:0]    ad_mask_reg, ad_ok_reg;
    logic [AW-1:0]    ad_addr_reg [0:PL-1];
    logic [2:0]       ad_sel_reg  [0:PL-1];

    always_comb
    begin
        logic [QW-1:0] sy, sx;
        logic [31:0]   full, wfull;
        ad_valid_next = dv_reg[DS].valid;
        ad_load_next  = dv_reg[DS].is_load;
        ad_oor_next   = dv_reg[DS].oor;
        ad_mask_next  = dv_reg[DS].mask;
        ad_wdata_next = dv_reg[DS].wdata;
        wfull         = 32'(dv_reg[DS].waddr);
        ad_wok_next   = (wfull < 32'(SRC_BYTES));
        ad_waddr_next = wfull[AW-1:0];
        sy = dv_reg[DS].quo[bnns_pkg::ROW_LANE];
        if (sy >= sh)
        begin
            sy = sh - 8'd1;
        end
        for (int b = 0; b < PL; b++)
        begin
            sx = dv_reg[DS].quo[b];
            if (sx >= sw)
            begin
                sx = sw - 8'd1;
            end
            full = 32'(sy) * 32'(src_rb) + 32'(sx >> 3);
            ad_ok_next[b]   = (full < 32'(SRC_BYTES));
            ad_addr_next[b] = full[AW-1:0];
            ad_sel_next[b]  = sx[2:0];
        end
    end

    // RAM stage
    logic          rm_valid_reg, rm_load_reg, rm_oor_reg;
    logic [PL-1:0] rm_mask_reg, rm_ok_reg;
    logic [2:0]    rm_sel_reg [0:PL-1];
    logic [7:0]    rm_rdata   [0:PL-1];

    genvar r;
    generate
        for (r = 0; r < PL; r++)
        begin : g_ram
            bnns_ram #(
                .WIDTH (8),
                .DEPTH (SRC_BYTES)
            ) u_ram (
                .clk   (clk),
                .we    (en && ad_valid_reg && ad_load_reg && ad_wok_reg),
                .waddr (ad_waddr_reg),
                .wdata (ad_wdata_reg),
                .re    (en && ad_valid_reg && !ad_load_reg),
                .raddr (ad_addr_reg[r]),
                .rdata (rm_rdata[r])
            );
        end
    endgenerate

    // output stage
    bnns_pkg::out_item_t out_data_next;

    always_comb
    begin
        out_data_next              = '0;
        out_data_next.out_of_range = rm_oor_reg;
        for (int b = 0; b < PL; b++)
        begin
            out_data_next.dst_byte[PL-1-b] = !rm_oor_reg && rm_mask_reg[b] && rm_ok_reg[b]
                                           && rm_rdata[b][3'd7 - rm_sel_reg[b]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            ad_valid_reg  <= 1'b0;
            rm_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s <= DS; s++)
            begin
                dv_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            s0_valid_reg  <= in_valid;
            ad_valid_reg  <= ad_valid_next;
            rm_valid_reg  <= ad_valid_reg;
            out_valid_reg <= rm_valid_reg && !rm_load_reg;
            for (int s = 0; s <= DS; s++)
            begin
                dv_reg[s] <= dv_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= in_data;
            ad_load_reg  <= ad_load_next;
            ad_wok_reg   <= ad_wok_next;
            ad_oor_reg   <= ad_oor_next;
            ad_waddr_reg <= ad_waddr_next;
            ad_wdata_reg <= ad_wdata_next;
            ad_mask_reg  <= ad_mask_next;
            ad_ok_reg    <= ad_ok_next;
            for (int b = 0; b < PL; b++)
            begin
                ad_addr_reg[b] <= ad_addr_next[b];
                ad_sel_reg[b]  <= ad_sel_next[b];
                rm_sel_reg[b]  <= ad_sel_reg[b];
            end
            rm_load_reg  <= ad_load_reg;
            rm_oor_reg   <= ad_oor_reg;
            rm_mask_reg  <= ad_mask_reg;
            rm_ok_reg    <= ad_ok_reg;
            out_data_reg <= out_data_next;
        end
    end

endmodule
